FILE: hdl/pshist_pkg.sv
`default_nettype none
package pshist_pkg;

    localparam int CAPACITY  = 1024;
    localparam int TOP_COUNT = 10;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int USED_W    = $clog2(CAPACITY + 1);
    localparam int RANK_W    = 6;
    localparam int PC_W      = 64;
    localparam int CNT_W     = 32;
    localparam int MDATA_W   = 104;

    typedef enum logic [0:0] {
        CMD_SAMPLE = 1'b0,
        CMD_REPORT = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S_NEW,
        ST_S_RD,
        ST_S_CMP,
        ST_R_RD,
        ST_R_CMP,
        ST_R_OUT,
        ST_R_WAIT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic clr_idx;
        logic inc_idx;
        logic wr_inc;
        logic wr_new;
        logic scan_clr;
        logic scan_upd;
        logic rep_start;
        logic out_load;
        logic rank_inc;
        logic clr_used;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic idx_last;
        logic used_zero;
        logic full;
        logic out_done;
        logic out_last;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: hdl/pc_sample_histogram_top_k.sv
// Profiling histogram of sampled program counters with a ranked report.
// The slave channel takes one word per command: s_tuser selects a sample
// (0) or a report (1), and s_tdata carries the PC of a sample.
// A sample walks the stored entries, one per read of the single read port
// of the entry memory, and either bumps the matching count (saturating)
// or appends a new entry with count one. A new PC is dropped when the
// table is full.
// A report produces TOP_COUNT words on the master channel, highest count
// first, ties to the lower PC, unused ranks as zero; m_tlast marks the
// final word. Each rank makes a full pass over the stored entries, then
// loads its word into the output register and hands it over.
// After the final word is taken the table is emptied.
// s_tready is high only while no command is in progress.
// When the receiver stalls, the current word holds and the block waits.
// Reset empties the table; no clearing pass is needed.
`default_nettype none
module pc_sample_histogram_top_k (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [63:0]    s_tdata,  // pc[63:0]
    input  wire logic           s_tuser,  // cmd
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [103:0]        m_tdata,  // rank[5:0], top_pc[69:6], hit_count[101:70]
    output logic                m_tlast
);
    import pshist_pkg::*;

    ctrl_cmd_t         cmd;
    dp_stat_t          stat;
    logic [RANK_W-1:0] out_rank;
    logic [PC_W-1:0]   out_pc;
    logic [CNT_W-1:0]  out_cnt;

    pshist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (cmd_t'(s_tuser)),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    pshist_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_pc     (s_tdata),
        .cmd       (cmd),
        .out_ready (m_tready),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_rank  (out_rank),
        .out_pc    (out_pc),
        .out_cnt   (out_cnt),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_cnt, out_pc, out_rank};

endmodule
`default_nettype wire

FILE: hdl/pshist_ctrl.sv
`default_nettype none
module pshist_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    input  wire pshist_pkg::cmd_t      in_cmd,
    input  wire pshist_pkg::dp_stat_t  stat,
    output logic                       in_ready,
    output pshist_pkg::ctrl_cmd_t      cmd
);
    import pshist_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_cmd == CMD_SAMPLE) begin
                        state_next = stat.used_zero ? ST_S_NEW : ST_S_RD;
                    end else begin
                        state_next = stat.used_zero ? ST_R_OUT : ST_R_RD;
                    end
                end
            end
            ST_S_NEW: state_next = ST_IDLE;
            ST_S_RD:  state_next = ST_S_CMP;
            ST_S_CMP: begin
                if (stat.hit || stat.idx_last) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_S_RD;
                end
            end
            ST_R_RD:  state_next = ST_R_CMP;
            ST_R_CMP: state_next = stat.idx_last ? ST_R_OUT : ST_R_RD;
            ST_R_OUT: state_next = ST_R_WAIT;
            ST_R_WAIT: begin
                if (stat.out_done) begin
                    if (stat.out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = stat.used_zero ? ST_R_OUT : ST_R_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in  = 1'b1;
                    cmd.clr_idx  = 1'b1;
                    cmd.scan_clr = 1'b1;
                    if (in_cmd == CMD_REPORT) begin
                        cmd.rep_start = 1'b1;
                    end
                end
            end
            ST_S_NEW: cmd.wr_new = 1'b1;
            ST_S_RD:  cmd = '0;
            ST_S_CMP: begin
                if (stat.hit) begin
                    cmd.wr_inc = 1'b1;
                end else if (stat.idx_last) begin
                    cmd.wr_new = !stat.full;
                end else begin
                    cmd.inc_idx = 1'b1;
                end
            end
            ST_R_RD:  cmd = '0;
            ST_R_CMP: begin
                cmd.scan_upd = 1'b1;
                cmd.inc_idx  = !stat.idx_last;
            end
            ST_R_OUT: cmd.out_load = 1'b1;
            ST_R_WAIT: begin
                if (stat.out_done) begin
                    if (stat.out_last) begin
                        cmd.clr_used = 1'b1;
                    end else begin
                        cmd.rank_inc = 1'b1;
                        cmd.clr_idx  = 1'b1;
                        cmd.scan_clr = 1'b1;
                    end
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/pshist_dp.sv
`default_nettype none
module pshist_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [pshist_pkg::PC_W-1:0]  in_pc,
    input  wire pshist_pkg::ctrl_cmd_t        cmd,
    input  wire logic                         out_ready,
    output pshist_pkg::dp_stat_t              stat,
    output logic                              out_valid,
    output logic [pshist_pkg::RANK_W-1:0]     out_rank,
    output logic [pshist_pkg::PC_W-1:0]       out_pc,
    output logic [pshist_pkg::CNT_W-1:0]      out_cnt,
    output logic                              out_last
);
    import pshist_pkg::*;

    logic [PC_W-1:0]   pc_mem  [CAPACITY];
    logic [CNT_W-1:0]  cnt_mem [CAPACITY];

    logic [PC_W-1:0]   in_pc_reg, rd_pc_reg, best_pc_reg, prev_pc_reg, out_pc_reg;
    logic [CNT_W-1:0]  rd_cnt_reg, best_cnt_reg, prev_cnt_reg, out_cnt_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [USED_W-1:0] used_reg;
    logic [RANK_W-1:0] rank_reg, out_rank_reg;
    logic              best_have_reg, prev_have_reg, out_valid_reg, out_last_reg;
    logic              eligible, better;
    logic [CNT_W-1:0]  cnt_inc;
    logic [IDX_W-1:0]  new_idx;

    assign cnt_inc = (rd_cnt_reg == '1) ? rd_cnt_reg : rd_cnt_reg + CNT_W'(1);
    assign new_idx = used_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        rd_pc_reg  <= pc_mem[idx_reg];
        rd_cnt_reg <= cnt_mem[idx_reg];
        if (cmd.wr_inc) begin
            cnt_mem[idx_reg] <= cnt_inc;
        end
        if (cmd.wr_new) begin
            pc_mem[new_idx]  <= in_pc_reg;
            cnt_mem[new_idx] <= CNT_W'(1);
        end
    end

    assign eligible = !prev_have_reg || (rd_cnt_reg < prev_cnt_reg) ||
                      (rd_cnt_reg == prev_cnt_reg && rd_pc_reg > prev_pc_reg);
    assign better   = !best_have_reg || (rd_cnt_reg > best_cnt_reg) ||
                      (rd_cnt_reg == best_cnt_reg && rd_pc_reg < best_pc_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_pc_reg <= in_pc;
        end
        if (cmd.scan_upd && eligible && better) begin
            best_pc_reg  <= rd_pc_reg;
            best_cnt_reg <= rd_cnt_reg;
        end
        if (cmd.out_load) begin
            prev_pc_reg  <= best_pc_reg;
            prev_cnt_reg <= best_cnt_reg;
            out_pc_reg   <= best_have_reg ? best_pc_reg : '0;
            out_cnt_reg  <= best_have_reg ? best_cnt_reg : '0;
            out_rank_reg <= rank_reg;
            out_last_reg <= (rank_reg == RANK_W'(TOP_COUNT - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            used_reg      <= '0;
            rank_reg      <= '0;
            best_have_reg <= 1'b0;
            prev_have_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_idx) begin
                idx_reg <= '0;
            end else if (cmd.inc_idx) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.clr_used) begin
                used_reg <= '0;
            end else if (cmd.wr_new) begin
                used_reg <= used_reg + USED_W'(1);
            end
            if (cmd.rep_start) begin
                rank_reg <= '0;
            end else if (cmd.rank_inc) begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
            if (cmd.scan_clr) begin
                best_have_reg <= 1'b0;
            end else if (cmd.scan_upd && eligible) begin
                best_have_reg <= 1'b1;
            end
            if (cmd.rep_start) begin
                prev_have_reg <= 1'b0;
            end else if (cmd.out_load && best_have_reg) begin
                prev_have_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.hit       = (rd_pc_reg == in_pc_reg);
        stat.idx_last  = ((USED_W'(idx_reg) + USED_W'(1)) == used_reg);
        stat.used_zero = (used_reg == '0);
        stat.full      = (used_reg == USED_W'(CAPACITY));
        stat.out_done  = out_valid_reg && out_ready;
        stat.out_last  = out_last_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_rank  = out_rank_reg;
    assign out_pc    = out_pc_reg;
    assign out_cnt   = out_cnt_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

FILE: hdl/pshist_checker.sv
`default_nettype none
module pshist_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [103:0] m_tdata,
    input wire logic         m_tlast
);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input accepted during a report");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled word changed");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("not idle after final word");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("output valid after reset");

endmodule

bind pc_sample_histogram_top_k pshist_checker u_pshist_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
